### sv/aabd_pkg.sv
package aabd_pkg;
  localparam int MAX_WIDTH = 4096;
  localparam int MAX_FACTOR = 64;

  localparam int PIX_W = 8;
  localparam int CODE_W = 7;
  localparam int LEVEL_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROWF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CMODE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DOL = 3'd5;

  typedef struct packed {
    logic load;
    logic divide;
    logic emit;
  } aabd_cmd_t;

  typedef struct packed {
    logic block_done;
    logic div_done;
    logic cnt_ready;
  } aabd_sts_t;

  function automatic logic [CODE_W-1:0] shade_code(input logic [LEVEL_W-1:0] i);
    logic [CODE_W-1:0] c;
    case (i)
      3'd0: c = 7'd64;
      3'd1: c = 7'd35;
      3'd2: c = 7'd37;
      3'd3: c = 7'd42;
      3'd4: c = 7'd124;
      3'd5: c = 7'd45;
      3'd6: c = 7'd46;
      default: c = 7'd32;
    endcase
    return c;
  endfunction
endpackage

### sv/aabd_ctrl.sv
module aabd_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  logic out_fire,
  input  aabd_pkg::aabd_sts_t sts,
  output aabd_pkg::aabd_cmd_t cmd,
  output logic busy,
  output logic take_ok
);
  import aabd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_LOAD;
      S_LOAD: state_nxt = sts.block_done ? S_DIV : S_IDLE;
      S_DIV: if (sts.div_done) state_nxt = S_OUT;
      S_OUT: if (out_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign cmd.load = (state_r == S_LOAD);
  assign cmd.divide = (state_r == S_DIV);
  assign cmd.emit = (state_r == S_OUT);
  assign busy = (state_r != S_IDLE);
  assign take_ok = (state_r == S_IDLE) && sts.cnt_ready;
endmodule

### sv/aabd_dp.sv
module aabd_dp (
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  logic [aabd_pkg::PIX_W-1:0] in_red,
  input  logic [aabd_pkg::PIX_W-1:0] in_green,
  input  logic [aabd_pkg::PIX_W-1:0] in_blue,
  input  logic cfg_fire,
  input  logic [aabd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [aabd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  aabd_pkg::aabd_cmd_t cmd,
  output aabd_pkg::aabd_sts_t sts,
  output logic [aabd_pkg::CODE_W-1:0] char_code,
  output logic [aabd_pkg::LEVEL_W-1:0] shade_level,
  output logic row_end,
  output logic frame_end
);
  import aabd_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int FW = $clog2(MAX_FACTOR + 1);
  localparam int DW = 13;
  localparam int RSW = 8 + $clog2(MAX_FACTOR);
  localparam int SW = 8 + 2 * $clog2(MAX_FACTOR);
  localparam int AREA_W = 2 * FW;
  localparam int SUBW = $clog2(MAX_FACTOR);

  logic [12:0] w_reg_r, h_reg_r;
  logic [6:0] cf_reg_r, rf_reg_r;
  logic cmode_r, dol_r;
  logic cfg_hit;

  logic [DW-1:0] w_c, h_c;
  logic [FW-1:0] cf_c, rf_c;
  logic [DW-1:0] ncol_r, nrow_r, ncolcf_r, nrowrf_r;
  logic [AREA_W-1:0] area_r;

  assign cfg_hit = cfg_fire && (cfg_idx <= REG_DOL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_reg_r <= 13'd64; h_reg_r <= 13'd64;
      cf_reg_r <= 7'd1; rf_reg_r <= 7'd1;
      cmode_r <= 1'b0; dol_r <= 1'b1;
    end else if (cfg_fire) begin
      unique case (cfg_idx)
        REG_WIDTH: w_reg_r <= cfg_data;
        REG_HEIGHT: h_reg_r <= cfg_data;
        REG_COLF: cf_reg_r <= cfg_data[6:0];
        REG_ROWF: rf_reg_r <= cfg_data[6:0];
        REG_CMODE: cmode_r <= cfg_data[0];
        REG_DOL: dol_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (w_reg_r == '0) w_c = DW'(1);
    else if (32'(w_reg_r) > MAX_WIDTH) w_c = DW'(MAX_WIDTH);
    else w_c = w_reg_r;
    if (h_reg_r == '0) h_c = DW'(1);
    else if (h_reg_r > 13'd4096) h_c = 13'd4096;
    else h_c = h_reg_r;
    if (cf_reg_r == '0) cf_c = FW'(1);
    else if (32'(cf_reg_r) > MAX_FACTOR) cf_c = FW'(MAX_FACTOR);
    else cf_c = FW'(cf_reg_r);
    if (rf_reg_r == '0) rf_c = FW'(1);
    else if (32'(rf_reg_r) > MAX_FACTOR) rf_c = FW'(MAX_FACTOR);
    else rf_c = FW'(rf_reg_r);
  end

  // block counts by repeated addition, restarted after any write or reset
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      ncol_r <= '0; nrow_r <= '0; ncolcf_r <= '0; nrowrf_r <= '0;
      area_r <= '0;
    end else begin
      area_r <= AREA_W'(cf_c * rf_c);
      if (ncolcf_r + DW'(cf_c) <= w_c) begin
        ncolcf_r <= ncolcf_r + DW'(cf_c);
        ncol_r <= ncol_r + 1'b1;
      end
      if (nrowrf_r + DW'(rf_c) <= h_c) begin
        nrowrf_r <= nrowrf_r + DW'(rf_c);
        nrow_r <= nrow_r + 1'b1;
      end
    end
  end

  assign sts.cnt_ready = ((ncolcf_r + DW'(cf_c)) > w_c) && ((nrowrf_r + DW'(rf_c)) > h_c);

  // gray conversion, or a fixed level by channel order when cmode is set
  logic [PIX_W-1:0] gray;
  logic [17:0] wsum;
  always_comb begin
    wsum = 18'(in_red) * 18'd299 + 18'(in_green) * 18'd587 + 18'(in_blue) * 18'd114;
    if (!cmode_r) gray = PIX_W'((35'(wsum) * 35'd67109) >> 26);
    else if (in_red == in_green && in_green == in_blue)
      gray = in_red[7] ? 8'd255 : 8'd31;
    else if (in_red >= in_green && in_green >= in_blue) gray = 8'd223;
    else if (in_green >= in_red && in_red >= in_blue) gray = 8'd191;
    else if (in_green >= in_blue && in_blue >= in_red) gray = 8'd159;
    else if (in_blue >= in_green && in_green >= in_red) gray = 8'd127;
    else if (in_blue >= in_red && in_red >= in_green) gray = 8'd95;
    else gray = 8'd63;
  end

  logic [AW-1:0] bcol_r;
  logic [DW-1:0] pcol_full_r, prow_r;
  logic [SUBW-1:0] scol_r, srow_r;
  logic [RSW-1:0] rsum_r;
  logic [SW-1:0] band [MAX_WIDTH];
  logic [SW-1:0] band_q_r;

  logic hold_close_r, hold_first_r, hold_last_r, hold_rend_r, hold_fend_r;
  logic [AW-1:0] hold_idx_r;
  logic [RSW-1:0] hold_rsum_r;
  logic [SW-1:0] total_r;

  logic row_act, act, close_blk, last_sub_row, wrap_col;
  assign row_act = prow_r < nrowrf_r;
  assign act = row_act && (pcol_full_r < ncolcf_r);
  assign close_blk = (32'(scol_r) + 1) >= 32'(cf_c);
  assign last_sub_row = (32'(srow_r) + 1) >= 32'(rf_c);
  assign wrap_col = (pcol_full_r + 1'b1) >= w_c;

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      pcol_full_r <= '0; prow_r <= '0; scol_r <= '0; srow_r <= '0;
      bcol_r <= '0; rsum_r <= '0; hold_close_r <= 1'b0;
    end else if (in_fire) begin
      hold_close_r <= act && close_blk;
      hold_first_r <= (srow_r == '0);
      hold_last_r <= last_sub_row;
      hold_idx_r <= bcol_r;
      hold_rsum_r <= rsum_r + RSW'(gray);
      hold_rend_r <= (DW'(bcol_r) + 1'b1) >= ncol_r;
      hold_fend_r <= ((DW'(bcol_r) + 1'b1) >= ncol_r) && ((prow_r + 1'b1) >= nrowrf_r);
      if (act) begin
        if (close_blk) begin
          rsum_r <= '0; scol_r <= '0; bcol_r <= bcol_r + 1'b1;
        end else begin
          rsum_r <= rsum_r + RSW'(gray); scol_r <= scol_r + 1'b1;
        end
      end
      if (wrap_col) begin
        pcol_full_r <= '0; scol_r <= '0; bcol_r <= '0; rsum_r <= '0;
        if ((prow_r + 1'b1) >= h_c) begin
          prow_r <= '0; srow_r <= '0;
        end else begin
          prow_r <= prow_r + 1'b1;
          if (row_act) srow_r <= last_sub_row ? '0 : srow_r + 1'b1;
        end
      end else begin
        pcol_full_r <= pcol_full_r + 1'b1;
      end
    end else if (cmd.load) begin
      hold_close_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) band_q_r <= band[bcol_r];
  end

  logic [SW-1:0] total_c;
  assign total_c = (hold_first_r ? '0 : band_q_r) + SW'(hold_rsum_r);

  always_ff @(posedge clk) begin
    if (cmd.load && hold_close_r) band[hold_idx_r] <= total_c;
  end

  assign sts.block_done = hold_close_r && hold_last_r;

  // restoring divider, one quotient bit a cycle
  localparam int QW = SW;
  localparam int CW = $clog2(QW + 1);
  logic [QW-1:0] quo_r;
  logic [AREA_W:0] rem_r;
  logic [CW-1:0] cnt_r;
  logic [AREA_W:0] trial;
  logic rend_r, fend_r;
  assign trial = {rem_r[AREA_W-1:0], total_r[QW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load) begin
      total_r <= total_c; quo_r <= '0; rem_r <= '0; cnt_r <= CW'(QW);
      rend_r <= hold_rend_r; fend_r <= hold_fend_r;
    end else if (cmd.divide && cnt_r != '0) begin
      total_r <= {total_r[QW-2:0], 1'b0};
      cnt_r <= cnt_r - 1'b1;
      if (trial >= {1'b0, area_r}) begin
        rem_r <= trial - {1'b0, area_r}; quo_r <= {quo_r[QW-2:0], 1'b1};
      end else begin
        rem_r <= trial; quo_r <= {quo_r[QW-2:0], 1'b0};
      end
    end
  end
  assign sts.div_done = (cnt_r == '0);

  logic [LEVEL_W-1:0] lvl;
  assign lvl = quo_r[7:5];
  assign shade_level = lvl;
  assign char_code = shade_code(dol_r ? (3'd7 - lvl) : lvl);
  assign row_end = rend_r;
  assign frame_end = fend_r;

  logic unused;
  assign unused = ^{cmd.emit};
endmodule

### sv/ascii_art_block_downscaler_top.sv
// ascii art block downscaler
// in_valid/in_stall carry one rgb pixel per transfer in raster order;
// out_valid/out_stall carry one shade character per finished block.
// cfg_valid/cfg_ready write a register by index; a write to index 0..5
// restarts the frame. after a write or reset the input is stalled while
// block counts are derived. a pixel that closes no block goes through
// the load state (band memory read, then update). a pixel that closes
// a whole block then runs a restoring divider; its character is valid
// once the division is done, and the next pixel is taken only after
// that character is transferred.
// while out_valid waits under out_stall no new pixel is taken.
// reset (rst_n low, synchronous) restores the register defaults and
// clears the position counters; band memory is not cleared, the first
// row of each block writes its entry without using the stale value.
module ascii_art_block_downscaler_top (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  output logic out_valid,
  input  logic out_stall,
  output logic [6:0] out_char_code,
  output logic [2:0] out_shade_level,
  output logic out_row_end,
  output logic out_frame_end,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [12:0] cfg_data
);
  import aabd_pkg::*;

  aabd_cmd_t cmd;
  aabd_sts_t sts;
  logic busy, take_ok, in_fire, out_fire, cfg_fire;

  assign in_stall = !take_ok || cfg_valid;
  assign in_fire = in_valid && !in_stall;
  assign out_valid = cmd.emit;
  assign out_fire = out_valid && !out_stall;
  assign cfg_ready = !busy;
  assign cfg_fire = cfg_valid && cfg_ready;

  aabd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
    .sts(sts), .cmd(cmd), .busy(busy), .take_ok(take_ok)
  );

  aabd_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .cfg_fire(cfg_fire), .cfg_idx(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .sts(sts),
    .char_code(out_char_code), .shade_level(out_shade_level),
    .row_end(out_row_end), .frame_end(out_frame_end)
  );
endmodule

### tb/sv/testbench.sv
module testbench;
  import aabd_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 4200;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_PCT = 63;
  localparam int BOTH_PCT = 18;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
  typedef enum logic {ROW_PIX, ROW_CFG} row_kind_t;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic [LEVEL_W-1:0] level;
    logic row_end;
    logic frame_end;
  } shade_t;

  typedef struct {
    row_kind_t kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] data;
    logic [7:0] r, g, b;
    bit typed;
    shade_t want;
  } stim_row_t;

  typedef struct {
    int w, h, cf, rf, cmode, dol, items;
  } frame_setup_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [7:0] in_red = 0, in_green = 0, in_blue = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [6:0] out_char_code;
  logic [2:0] out_shade_level;
  logic out_row_end, out_frame_end;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = 0;
  logic [12:0] cfg_data = 0;

  ascii_art_block_downscaler_top dut (.*);

  // predictor state
  logic [12:0] reg_w, reg_h;
  logic [6:0] reg_cf, reg_rf;
  logic reg_cmode, reg_dol;
  logic [19:0] band [4096];
  int pcol, prow, scol, srow, bcol, rsum;

  shade_t shade_q[$];
  int errors = 0;
  int cycles = 0;
  idle_mode_t idle_mode = IDLE_NONE;
  bit hold_req = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic int gray_of(int r, int g, int b);
    if (!reg_cmode) return (299 * r + 587 * g + 114 * b) / 1000;
    if (r == g && g == b) return r < 128 ? 31 : 255;
    if (r >= g && g >= b) return 223;
    if (g >= r && r >= b) return 191;
    if (g >= b && b >= r) return 159;
    if (b >= g && g >= r) return 127;
    if (b >= r && r >= g) return 95;
    return 63;
  endfunction

  function automatic int clip(int v, int hi);
    return v < 1 ? 1 : (v > hi ? hi : v);
  endfunction

  function automatic void restart_frame();
    pcol = 0; prow = 0; scol = 0; srow = 0; bcol = 0; rsum = 0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_WIDTH: reg_w = d;
      REG_HEIGHT: reg_h = d;
      REG_COLF: reg_cf = d[6:0];
      REG_ROWF: reg_rf = d[6:0];
      REG_CMODE: reg_cmode = d[0];
      REG_DOL: reg_dol = d[0];
      default: return;
    endcase
    restart_frame();
  endfunction

  function automatic void predict_pixel(int r, int g, int b);
    int w, h, cf, rf, ncol, nrow, total, lvl;
    bit row_act;
    shade_t s;
    w = clip(int'(reg_w), 4096);
    h = clip(int'(reg_h), 4096);
    cf = clip(int'(reg_cf), 64);
    rf = clip(int'(reg_rf), 64);
    ncol = w / cf;
    nrow = h / rf;
    row_act = prow < nrow * rf;
    if (row_act && pcol < ncol * cf) begin
      rsum += gray_of(r, g, b);
      if (scol + 1 >= cf) begin
        total = (srow == 0 ? 0 : int'(band[bcol % 4096])) + rsum;
        band[bcol % 4096] = total[19:0];
        rsum = 0;
        if (srow + 1 >= rf) begin
          lvl = ((total / (cf * rf)) / 32) & 7;
          s.level = lvl[2:0];
          s.code = shade_code(reg_dol ? 3'd7 - s.level : s.level);
          s.row_end = bcol + 1 >= ncol;
          s.frame_end = s.row_end && prow + 1 >= nrow * rf;
          shade_q.push_back(s);
        end
        bcol++;
        scol = 0;
      end else begin
        scol++;
      end
    end
    pcol++;
    if (pcol >= w) begin
      pcol = 0; scol = 0; bcol = 0; rsum = 0;
      if (row_act) srow = (srow + 1 >= rf) ? 0 : srow + 1;
      prow++;
      if (prow >= h) begin
        prow = 0;
        srow = 0;
      end
    end
  endfunction

  // result side: check the transfer, then pick the next stall value
  int hold_left = 0;
  always @(posedge clk) begin
    shade_t s;
    if (rst_n && out_valid && !out_stall) begin
      if (shade_q.size() == 0) begin
        $error("unexpected transfer char_code %0d", out_char_code);
        errors++;
      end else begin
        s = shade_q.pop_front();
        if (out_char_code !== s.code) begin
          $error("char_code expected %0d actual %0d", s.code, out_char_code);
          errors++;
        end
        if (out_shade_level !== s.level) begin
          $error("shade_level expected %0d actual %0d", s.level, out_shade_level);
          errors++;
        end
        if (out_row_end !== s.row_end) begin
          $error("row_end expected %0d actual %0d", s.row_end, out_row_end);
          errors++;
        end
        if (out_frame_end !== s.frame_end) begin
          $error("frame_end expected %0d actual %0d", s.frame_end, out_frame_end);
          errors++;
        end
      end
    end
    if (hold_req && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (idle_mode == IDLE_RECV) begin
      out_stall <= ($urandom_range(99) < IDLE_PCT);
    end else if (idle_mode == IDLE_BOTH) begin
      out_stall <= ($urandom_range(99) < BOTH_PCT);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_pixel(logic [7:0] r, g, b, bit typed, shade_t want);
    int pct;
    in_valid <= 1'b1;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    do @(posedge clk); while (in_stall);
    predict_pixel(int'(r), int'(g), int'(b));
    if (typed) begin
      void'(shade_q.pop_back());
      shade_q.push_back(want);
    end
    pct = (idle_mode == IDLE_SEND) ? IDLE_PCT : ((idle_mode == IDLE_BOTH) ? BOTH_PCT : 0);
    if ($urandom_range(99) < pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic go_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (shade_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, d);
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic stim_row_t pix(int r, g, b);
    stim_row_t t;
    t.kind = ROW_PIX; t.r = 8'(r); t.g = 8'(g); t.b = 8'(b); t.typed = 0;
    t.idx = '0; t.data = '0; t.want = '{'0, '0, 1'b0, 1'b0};
    return t;
  endfunction

  function automatic stim_row_t pix_t(int r, g, b, int code, int lvl);
    stim_row_t t;
    t = pix(r, g, b);
    t.typed = 1;
    t.want = '{CODE_W'(code), LEVEL_W'(lvl), 1'b0, 1'b0};
    return t;
  endfunction

  function automatic stim_row_t cfg(logic [CFG_IDX_W-1:0] idx, int d);
    stim_row_t t;
    t = pix(0, 0, 0);
    t.kind = ROW_CFG; t.idx = idx; t.data = CFG_DATA_W'(d);
    return t;
  endfunction

  stim_row_t directed[$];
  frame_setup_t setups[$];

  initial begin
    logic [7:0] r, g, b;
    int k;
    shade_t none;
    none = '{'0, '0, 1'b0, 1'b0};
    reg_w = 64; reg_h = 64; reg_cf = 1; reg_rf = 1; reg_cmode = 0; reg_dol = 1;
    restart_frame();

    directed = '{
      pix_t(0, 0, 0, 32, 0), pix_t(255, 255, 255, 64, 7), pix_t(255, 0, 0, 45, 2),
      pix_t(0, 255, 0, 42, 4), pix_t(0, 0, 255, 32, 0),
      cfg(REG_CMODE, 1),
      pix_t(10, 10, 10, 32, 0), pix_t(200, 200, 200, 64, 7),
      pix_t(128, 128, 128, 64, 7), pix_t(127, 127, 127, 32, 0),
      pix_t(200, 100, 50, 35, 6), pix_t(100, 200, 50, 37, 5), pix_t(50, 200, 100, 42, 4),
      pix_t(50, 100, 200, 124, 3), pix_t(100, 50, 200, 45, 2), pix_t(200, 50, 100, 46, 1),
      cfg(REG_DOL, 0),
      pix_t(200, 100, 50, 46, 6),
      cfg(REG_WIDTH, 3), cfg(REG_COLF, 2),
      pix(90, 180, 20), pix(255, 255, 0), pix(7, 8, 9)
    };
    setups = '{
      '{16, 8, 1, 1, 0, 1, 300}, '{20, 13, 3, 2, 1, 0, 300}, '{0, 0, 0, 0, 0, 1, 60},
      '{64, 64, 127, 0, 1, 1, 200}, '{2, 130, 2, 100, 0, 0, 300},
      '{8191, 8191, 64, 1, 0, 1, 300}, '{3, 5, 5, 7, 1, 0, 60},
      '{7, 6, 7, 6, 1, 1, 200}, '{12, 10, 4, 5, 0, 0, 200}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        go_quiet();
        write_reg(directed[i].idx, directed[i].data);
        end_writes();
      end else begin
        send_pixel(directed[i].r, directed[i].g, directed[i].b, directed[i].typed,
                   directed[i].want);
      end
    end

    foreach (setups[p]) begin
      go_quiet();
      idle_mode = IDLE_NONE;
      write_reg(REG_WIDTH, CFG_DATA_W'(setups[p].w));
      write_reg(REG_HEIGHT, CFG_DATA_W'(setups[p].h));
      write_reg(REG_COLF, CFG_DATA_W'(setups[p].cf));
      write_reg(REG_ROWF, CFG_DATA_W'(setups[p].rf));
      write_reg(REG_CMODE, CFG_DATA_W'(setups[p].cmode));
      write_reg(REG_DOL, CFG_DATA_W'(setups[p].dol));
      end_writes();
      idle_mode = idle_mode_t'(p % 4);
      if (p == 0) hold_req = 1;
      for (k = 0; k < setups[p].items; k++) begin
        case ($urandom_range(9))
          0: begin
            r = $urandom_range(1) ? 8'hff : 8'h00;
            g = $urandom_range(1) ? 8'hff : 8'h00;
            b = $urandom_range(1) ? 8'hff : 8'h00;
          end
          1, 2: begin
            r = 8'($urandom_range(255));
            g = r;
            b = r;
          end
          default: begin
            r = 8'($urandom_range(255));
            g = 8'($urandom_range(255));
            b = 8'($urandom_range(255));
          end
        endcase
        send_pixel(r, g, b, 0, none);
      end
    end

    idle_mode = IDLE_NONE;
    go_quiet();
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
